// ===== src/qrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package qrm_pkg;

  // Quaternion component slots, scalar last.
  localparam int NUM_COMPS = 4;
  localparam int C_X = 0;
  localparam int C_Y = 1;
  localparam int C_Z = 2;
  localparam int C_W = 3;

  // Distinct products needed by the nine matrix entries.
  localparam int NUM_PRODUCTS = 10;
  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_WW = 3;
  localparam int P_XY = 4;
  localparam int P_XZ = 5;
  localparam int P_YZ = 6;
  localparam int P_WX = 7;
  localparam int P_WY = 8;
  localparam int P_WZ = 9;

  // Matrix entries in row-major order.
  localparam int NUM_ENTRIES = 9;
  localparam int E_00 = 0;
  localparam int E_01 = 1;
  localparam int E_02 = 2;
  localparam int E_10 = 3;
  localparam int E_11 = 4;
  localparam int E_12 = 5;
  localparam int E_20 = 6;
  localparam int E_21 = 7;
  localparam int E_22 = 8;

endpackage
`default_nettype wire

// ===== src/qrm_mult.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qrm_mult #(
  parameter int CB = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CB-1:0] comp [qrm_pkg::NUM_COMPS],
  output logic signed [2*CB-1:0] prod [qrm_pkg::NUM_PRODUCTS]
);
  import qrm_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod[P_XX] <= comp[C_X] * comp[C_X];
      prod[P_YY] <= comp[C_Y] * comp[C_Y];
      prod[P_ZZ] <= comp[C_Z] * comp[C_Z];
      prod[P_WW] <= comp[C_W] * comp[C_W];
      prod[P_XY] <= comp[C_X] * comp[C_Y];
      prod[P_XZ] <= comp[C_X] * comp[C_Z];
      prod[P_YZ] <= comp[C_Y] * comp[C_Z];
      prod[P_WX] <= comp[C_W] * comp[C_X];
      prod[P_WY] <= comp[C_W] * comp[C_Y];
      prod[P_WZ] <= comp[C_W] * comp[C_Z];
    end
  end

endmodule
`default_nettype wire

// ===== src/qrm_sum.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qrm_sum #(
  parameter int CB = 16,
  parameter int SW = 35
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [2*CB-1:0] prod [qrm_pkg::NUM_PRODUCTS],
  output logic signed [SW-1:0]   acc  [qrm_pkg::NUM_ENTRIES]
);
  import qrm_pkg::*;

  logic signed [SW-1:0] p [NUM_PRODUCTS];

  always_comb begin
    for (int i = 0; i < NUM_PRODUCTS; i++) begin
      p[i] = SW'(prod[i]);
    end
  end

  // Off-diagonal entries are twice a two-term sum; the doubling is a shift.
  always_ff @(posedge clk) begin
    if (en) begin
      acc[E_00] <= p[P_WW] + p[P_XX] - p[P_YY] - p[P_ZZ];
      acc[E_11] <= p[P_WW] - p[P_XX] + p[P_YY] - p[P_ZZ];
      acc[E_22] <= p[P_WW] - p[P_XX] - p[P_YY] + p[P_ZZ];
      acc[E_01] <= (p[P_XY] + p[P_WZ]) <<< 1;
      acc[E_10] <= (p[P_XY] - p[P_WZ]) <<< 1;
      acc[E_02] <= (p[P_XZ] - p[P_WY]) <<< 1;
      acc[E_20] <= (p[P_XZ] + p[P_WY]) <<< 1;
      acc[E_12] <= (p[P_YZ] + p[P_WX]) <<< 1;
      acc[E_21] <= (p[P_YZ] - p[P_WX]) <<< 1;
    end
  end

endmodule
`default_nettype wire

// ===== src/qrm_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qrm_round #(
  parameter int CB = 16,
  parameter int FB = 14,
  parameter int SW = 35
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [SW-1:0] acc [qrm_pkg::NUM_ENTRIES],
  output logic signed [CB-1:0] ent [qrm_pkg::NUM_ENTRIES]
);
  import qrm_pkg::*;

  localparam logic signed [SW-1:0] HALF = SW'(1) << (FB - 1);
  localparam logic signed [SW-1:0] MAXV = {{(SW - CB + 1){1'b0}}, {(CB - 1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  logic signed [SW-1:0] rnd [NUM_ENTRIES];
  logic signed [SW-1:0] sh  [NUM_ENTRIES];
  logic signed [CB-1:0] sat [NUM_ENTRIES];

  // Adding half an LSB before the arithmetic shift rounds ties upward.
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      rnd[i] = acc[i] + HALF;
      sh[i]  = rnd[i] >>> FB;
      if (sh[i] > MAXV) begin
        sat[i] = MAXV[CB-1:0];
      end else if (sh[i] < MINV) begin
        sat[i] = MINV[CB-1:0];
      end else begin
        sat[i] = sh[i][CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent <= sat;
    end
  end

endmodule
`default_nettype wire

// ===== src/quaternion_to_rotation_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Converts one quaternion (x, y, z, scalar w last) in signed fixed point into
// the nine entries of its 3x3 rotation matrix in the transposed, scalar-last
// convention, e.g. r00 = w2+x2-y2-z2 and r01 = 2xy+2wz. The input is not
// normalized, so entries scale with the squared norm. Each entry is rounded to
// nearest (ties upward) and saturated to the component range. The datapath is
// a four-register pipeline: input capture, ten multipliers, the nine sums, and
// round/saturate into the output register. While no stall holds the pipeline,
// a quaternion can be taken on every clock; a beat moves through the capture,
// product, sum and output registers in order, and m_tvalid marks the last one.
// Backpressure holds the whole pipeline in place while empty stages still fill,
// and the block is ready whenever any stage is free.
module quaternion_to_rotation_matrix #(
  parameter int COMPONENT_BITS = 16,
  parameter int FRACTION_BITS  = 14,
  localparam int IN_W  = ((4 * COMPONENT_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((9 * COMPONENT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // comp_x, comp_y, comp_z, comp_w, zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata   // r00, r01, r02, r10, r11, r12, r20, r21, r22, zero pad
);
  import qrm_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int SW = (2 * CB + 3 > FB + 2) ? 2 * CB + 3 : FB + 2;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic signed [CB-1:0]   comp [NUM_COMPS];
  logic signed [2*CB-1:0] prod [NUM_PRODUCTS];
  logic signed [SW-1:0]   acc  [NUM_ENTRIES];
  logic signed [CB-1:0]   ent  [NUM_ENTRIES];

  // A stage loads when it is empty or its contents move on.
  assign en4 = !v4 || m_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign s_tready = en1;
  assign m_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < NUM_COMPS; i++) begin
        comp[i] <= s_tdata[i*CB +: CB];
      end
    end
  end

  qrm_mult #(
    .CB(CB)
  ) u_mult (
    .clk (clk),
    .en  (en2),
    .comp(comp),
    .prod(prod)
  );

  qrm_sum #(
    .CB(CB),
    .SW(SW)
  ) u_sum (
    .clk (clk),
    .en  (en3),
    .prod(prod),
    .acc (acc)
  );

  qrm_round #(
    .CB(CB),
    .FB(FB),
    .SW(SW)
  ) u_round (
    .clk(clk),
    .en (en4),
    .acc(acc),
    .ent(ent)
  );

  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      m_tdata[i*CB +: CB] = ent[i];
    end
  end

endmodule
`default_nettype wire

// ===== src/qrm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qrm_checker #(
  parameter int IN_W  = 64,
  parameter int OUT_W = 144
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // A stalled output beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // With an empty output register every stage can take a beat.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output is empty");

  // With the output draining, a taken beat comes out once it has passed through every pipeline stage.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("beat missing after pipeline latency");

  // The zero quaternion maps to the zero matrix.
  a_zero_in: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata == '0 ##1 m_tready ##1 m_tready ##1 m_tready
    |=> m_tdata == '0)
    else $error("zero quaternion gave a nonzero matrix");

endmodule

bind quaternion_to_rotation_matrix qrm_checker #(
  .IN_W (IN_W),
  .OUT_W(OUT_W)
) u_qrm_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
`default_nettype wire

// ===== sim/quaternion_to_rotation_matrix_tb.sv =====
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix_tb;
  import qrm_pkg::*;

  localparam int CB = 16;
  localparam int FB = 14;
  localparam int N_RANDOM = 530;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT = 16;
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 300;

  // Packed so that x lands in the lowest bits of s_tdata.
  typedef struct packed {
    logic signed [CB-1:0] w;
    logic signed [CB-1:0] z;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] x;
  } quat_t;

  typedef struct {
    quat_t q;
    bit    drain_first;
  } quat_item_t;

  typedef logic [NUM_ENTRIES-1:0][CB-1:0] matrix_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;   // comp_x, comp_y, comp_z, comp_w
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;        // r00, r01, r02, r10, r11, r12, r20, r21, r22

  quat_item_t pending_quats[$];
  matrix_t    expected_matrices[$];
  string      entry_name [NUM_ENTRIES] = '{"r00", "r01", "r02", "r10", "r11", "r12",
                                           "r20", "r21", "r22"};

  logic in_taken = 1'b0;
  int   errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_saturated = 0;
  int   n_in_stalls = 0;
  int   cycles = 0;

  quaternion_to_rotation_matrix dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [CB-1:0] round_sat(longint acc);
    longint r;
    longint maxv;
    maxv = (longint'(1) <<< (CB - 1)) - 1;
    r = (acc + (longint'(1) <<< (FB - 1))) >>> FB;
    if (r > maxv) r = maxv;
    if (r < -maxv - 1) r = -maxv - 1;
    return r[CB-1:0];
  endfunction

  function automatic matrix_t rotation_of(quat_t q);
    longint x, y, z, w;
    longint xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
    matrix_t m;
    x = $signed(q.x);
    y = $signed(q.y);
    z = $signed(q.z);
    w = $signed(q.w);
    xx = x * x; yy = y * y; zz = z * z; ww = w * w;
    xy = x * y; xz = x * z; yz = y * z;
    wx = w * x; wy = w * y; wz = w * z;
    m[E_00] = round_sat(ww + xx - yy - zz);
    m[E_01] = round_sat(2 * xy + 2 * wz);
    m[E_02] = round_sat(2 * xz - 2 * wy);
    m[E_10] = round_sat(2 * xy - 2 * wz);
    m[E_11] = round_sat(ww - xx + yy - zz);
    m[E_12] = round_sat(2 * yz + 2 * wx);
    m[E_20] = round_sat(2 * xz + 2 * wy);
    m[E_21] = round_sat(2 * yz - 2 * wx);
    m[E_22] = round_sat(ww - xx - yy + zz);
    return m;
  endfunction

  task automatic add_quat(input int x, input int y, input int z, input int w,
                          input bit drain_first);
    quat_item_t it;
    it.q.x = x[CB-1:0];
    it.q.y = y[CB-1:0];
    it.q.z = z[CB-1:0];
    it.q.w = w[CB-1:0];
    it.drain_first = drain_first;
    pending_quats.push_back(it);
  endtask

  // One component drawn from a mix of full-range, near-unit, small and corner values.
  function automatic int random_comp(int style);
    case (style)
      0: return int'($urandom_range(65535)) - 32768;
      1: return int'($urandom_range(32768)) - 16384;
      2: return int'($urandom_range(512)) - 256;
      default: begin
        case ($urandom_range(7))
          0: return -32768;
          1: return 32767;
          2: return 0;
          3: return 1;
          4: return -1;
          5: return 16384;
          6: return -16384;
          default: return int'($urandom_range(65535)) - 32768;
        endcase
      end
    endcase
  endfunction

  // Sender: bursts of beats separated by random gaps; some items wait for a full drain.
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    quat_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_taken) begin
      s_tvalid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      s_tvalid <= 1'b0;
    end else if (pending_quats.size() == 0) begin
      s_tvalid <= 1'b0;
    end else if (pending_quats[0].drain_first && expected_matrices.size() != 0) begin
      s_tvalid <= 1'b0;
    end else begin
      it = pending_quats.pop_front();
      s_tdata <= it.q;
      s_tvalid <= 1'b1;
      if (burst_left > 0) begin
        burst_left = burst_left - 1;
      end else begin
        burst_left = $urandom_range(30);
        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
      end
    end
  end

  // Receiver: stall pattern changes at random intervals, plus one long hold-off.
  int rx_mode = 0;
  int rx_mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_done && n_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(3);
        rx_mode_left = $urandom_range(80, 20);
      end else begin
        rx_mode_left = rx_mode_left - 1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(1));
          2: m_tready <= ($urandom_range(3) == 0);
          default: m_tready <= cycles[0];
        endcase
      end
    end
  end

  // Input and output beats are both observed here at the rising edge.
  always @(posedge clk) begin
    matrix_t want;
    matrix_t got;
    in_taken <= s_tvalid && s_tready;
    if (!rst && s_tvalid && !s_tready) n_in_stalls = n_in_stalls + 1;
    if (!rst && s_tvalid && s_tready) begin
      expected_matrices.push_back(rotation_of(quat_t'(s_tdata)));
      n_sent = n_sent + 1;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_matrices.size() == 0) begin
        $error("matrix beat with no quaternion outstanding: %h", m_tdata);
        errors = errors + 1;
      end else begin
        want = expected_matrices.pop_front();
        n_checked = n_checked + 1;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if ($signed(want[i]) == 32767 || $signed(want[i]) == -32768)
            n_saturated = n_saturated + 1;
          if (got[i] !== want[i]) begin
            $error("%s expected %0d got %0d", entry_name[i], $signed(want[i]),
                   $signed(got[i]));
            errors = errors + 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("quaternion_to_rotation_matrix test failed");
      $finish;
    end
  end

  initial begin
    int style;
    // Zero, identity and sign flips of the scalar.
    add_quat(0, 0, 0, 0, 1'b0);
    add_quat(0, 0, 0, 16384, 1'b0);
    add_quat(0, 0, 0, -16384, 1'b0);
    // Half turns about each axis and quarter turns in both directions.
    add_quat(16384, 0, 0, 0, 1'b0);
    add_quat(0, 16384, 0, 0, 1'b0);
    add_quat(0, 0, 16384, 0, 1'b0);
    add_quat(11585, 0, 0, 11585, 1'b0);
    add_quat(0, -11585, 0, 11585, 1'b0);
    add_quat(0, 0, 11585, -11585, 1'b0);
    add_quat(8192, 8192, 8192, 8192, 1'b0);
    // Corners of the input range; these saturate many entries.
    add_quat(32767, 32767, 32767, 32767, 1'b0);
    add_quat(-32768, -32768, -32768, -32768, 1'b0);
    add_quat(-32768, 0, 0, 0, 1'b0);
    add_quat(0, 0, 0, -32768, 1'b0);
    add_quat(32767, -32768, 32767, -32768, 1'b0);
    add_quat(0, -32768, -32768, 0, 1'b0);
    add_quat(-32768, 32767, -32768, 32767, 1'b0);
    // Exact halves: a positive tie rounds up, a negative tie rounds toward zero.
    add_quat(64, 64, 0, 0, 1'b0);
    add_quat(64, -64, 0, 0, 1'b0);
    add_quat(1, 1, 1, 1, 1'b0);
    add_quat(-1, -1, -1, -1, 1'b0);
    add_quat(90, 91, 0, 0, 1'b0);
    add_quat(0, 0, 0, 1, 1'b0);
    for (int i = 0; i < N_RANDOM; i++) begin
      style = $urandom_range(99);
      style = (style < 40) ? 0 : (style < 70) ? 1 : (style < 85) ? 2 : 3;
      add_quat(random_comp(style), random_comp(style), random_comp(style),
               random_comp(style), (i == 300) || ($urandom_range(99) == 0));
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    do @(posedge clk); while (pending_quats.size() != 0 || s_tvalid);
    while (expected_matrices.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d quaternions and checked %0d matrices, %0d entries at a saturation limit.",
             n_sent, n_checked, n_saturated);
    $display("The input was stalled on %0d cycles, with one long output hold-off.",
             n_in_stalls);
    if (errors == 0) begin
      $display("quaternion_to_rotation_matrix test passed");
    end else begin
      $display("quaternion_to_rotation_matrix test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/qrm_pkg.sv
src/qrm_mult.sv
src/qrm_sum.sv
src/qrm_round.sv
src/quaternion_to_rotation_matrix.sv
src/qrm_checker.sv
sim/quaternion_to_rotation_matrix_tb.sv
